@@ hdl/utf8_stream_decoder_with_replay_macros.svh @@
`ifndef UTF8_STREAM_DECODER_WITH_REPLAY_MACROS_SVH
`define UTF8_STREAM_DECODER_WITH_REPLAY_MACROS_SVH

`ifndef SYNTHESIS
`define U8D_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("u8d assertion failed");
`define U8D_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("u8d reset assertion failed");
`else
`define U8D_ASSERT(lbl, clk, rst_n, prop)
`define U8D_ASSERT_RST(lbl, clk, prop)
`endif

`endif

@@ hdl/u8d_pkg.sv @@
package u8d_pkg;

    localparam int CP_W = 21;
    localparam int CNT_W = 3;
    localparam int SEL_W = 2;
    localparam int HELD_DEPTH = 3;
    localparam int RES_DEPTH = 4;

    localparam logic [CP_W-1:0] ESC_BASE = 21'h00DC00;
    localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;
    localparam logic [CP_W-1:0] BMP_MAX = 21'h00FFFF;
    localparam logic [CP_W-1:0] MIN_2B = 21'h000080;
    localparam logic [CP_W-1:0] MIN_3B = 21'h000800;
    localparam logic [CP_W-1:0] MIN_4B = 21'h010000;
    localparam logic [7:0] ESC_HI = 8'hDC;
    localparam logic [7:0] LEAD_LIMIT = 8'hF5;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic is_end;
        logic range_error;
    } res_t;

    typedef struct packed {
        logic load;
        logic [SEL_W-1:0] sel;
    } dp_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
    } dp_stat_t;

endpackage

@@ hdl/u8d_datapath.sv @@
module u8d_datapath
    import u8d_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic cfg_wr_en,
    input  logic cfg_wr_data,
    input  logic [7:0] in_byte,
    input  logic end_of_input,
    input  dp_cmd_t cmd,
    output dp_stat_t stat,
    output res_t res_out
);

    logic fue_reg;
    logic [1:0] rem_reg, rem_next;
    logic [CP_W-1:0] partial_reg, partial_next;
    logic [CP_W-1:0] min_reg, min_next;
    logic [1:0] hc_reg, hc_next;
    logic [7:0] held_reg [HELD_DEPTH];
    logic [7:0] held_next [HELD_DEPTH];
    res_t res_buf_reg [RES_DEPTH];
    res_t res_buf_next [RES_DEPTH];

    logic id_emit;
    res_t id_res;
    logic id_start;
    logic [1:0] id_rem;
    logic [CP_W-1:0] id_val;
    logic [CP_W-1:0] id_min;

    logic flush;
    logic tail_v;
    res_t tail;
    logic [1:0] rem_dec;
    logic [CP_W-1:0] new_partial;
    logic bad;
    logic [1:0] base;

    always_comb begin
        id_emit = 1'b0;
        id_res = '{code_point: ESC_BASE | {13'd0, in_byte}, is_end: 1'b0, range_error: 1'b0};
        id_start = 1'b0;
        id_rem = 2'd0;
        id_val = '0;
        id_min = '0;
        if (!in_byte[7]) begin
            id_emit = 1'b1;
            id_res.code_point = {13'd0, in_byte};
        end else if (in_byte[7:5] == 3'b110) begin
            id_start = 1'b1;
            id_rem = 2'd1;
            id_val = {16'd0, in_byte[4:0]};
            id_min = MIN_2B;
        end else if (in_byte[7:4] == 4'hE) begin
            id_start = 1'b1;
            id_rem = 2'd2;
            id_val = {17'd0, in_byte[3:0]};
            id_min = MIN_3B;
        end else if (in_byte[7:4] == 4'hF) begin
            if (!fue_reg) begin
                id_emit = 1'b1;
                id_res = '{code_point: '0, is_end: 1'b0, range_error: 1'b1};
            end else if (in_byte < LEAD_LIMIT) begin
                id_start = 1'b1;
                id_rem = 2'd3;
                id_val = {18'd0, in_byte[2:0]};
                id_min = MIN_4B;
            end else begin
                id_emit = 1'b1;
            end
        end else begin
            id_emit = 1'b1;
        end
    end

    assign rem_dec = rem_reg - 2'd1;
    assign new_partial = {partial_reg[CP_W-7:0], in_byte[5:0]};
    assign bad = (new_partial < min_reg) ||
                 ((new_partial <= BMP_MAX) && (new_partial[15:8] == ESC_HI)) ||
                 (new_partial > CP_MAX);

    always_comb begin
        flush = 1'b0;
        tail_v = 1'b0;
        tail = '{code_point: ESC_BASE | {13'd0, in_byte}, is_end: 1'b0, range_error: 1'b0};
        rem_next = rem_reg;
        partial_next = partial_reg;
        min_next = min_reg;
        hc_next = hc_reg;
        held_next = held_reg;
        if (end_of_input) begin
            flush = (rem_reg != 2'd0);
            tail_v = 1'b1;
            tail = '{code_point: '0, is_end: 1'b1, range_error: 1'b0};
            rem_next = 2'd0;
            partial_next = '0;
            min_next = '0;
            hc_next = 2'd0;
        end else if (rem_reg != 2'd0 && in_byte[7:6] == 2'b10) begin
            partial_next = new_partial;
            rem_next = rem_dec;
            if (rem_dec != 2'd0) begin
                if (hc_reg != 2'd3) begin
                    held_next[hc_reg] = in_byte;
                    hc_next = hc_reg + 2'd1;
                end
            end else begin
                flush = bad;
                tail_v = 1'b1;
                if (!bad) begin
                    tail.code_point = new_partial;
                end
                partial_next = '0;
                min_next = '0;
                hc_next = 2'd0;
            end
        end else begin
            flush = (rem_reg != 2'd0);
            tail_v = id_emit;
            tail = id_res;
            rem_next = id_rem;
            partial_next = id_val;
            min_next = id_min;
            hc_next = 2'd0;
            if (id_start) begin
                held_next[0] = in_byte;
                hc_next = 2'd1;
            end
        end
    end

    assign base = flush ? hc_reg : 2'd0;
    assign stat.count = {1'b0, base} + {2'd0, tail_v};

    always_comb begin
        for (int i = 0; i < HELD_DEPTH; i++) begin
            if (SEL_W'(i) < base) begin
                res_buf_next[i] = '{code_point: ESC_BASE | {13'd0, held_reg[i]},
                                    is_end: 1'b0, range_error: 1'b0};
            end else begin
                res_buf_next[i] = tail;
            end
        end
        res_buf_next[RES_DEPTH-1] = tail;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fue_reg <= 1'b1;
            rem_reg <= 2'd0;
            partial_reg <= '0;
            min_reg <= '0;
            hc_reg <= 2'd0;
        end else begin
            if (cfg_wr_en) begin
                fue_reg <= cfg_wr_data;
            end
            if (cmd.load) begin
                rem_reg <= rem_next;
                partial_reg <= partial_next;
                min_reg <= min_next;
                hc_reg <= hc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            held_reg <= held_next;
            res_buf_reg <= res_buf_next;
        end
    end

    assign res_out = res_buf_reg[cmd.sel];

endmodule

@@ hdl/u8d_ctrl.sv @@
`include "utf8_stream_decoder_with_replay_macros.svh"

module u8d_ctrl
    import u8d_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    output logic m_tlast,
    input  dp_stat_t stat,
    output dp_cmd_t cmd
);

    localparam logic ST_ACCEPT = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic state_reg, state_next;
    logic [SEL_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic is_last;
    logic load;

    assign is_last = (({1'b0, idx_reg} + 3'd1) == cnt_reg);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tlast = is_last;
    assign s_tready = (state_reg == ST_ACCEPT) ||
                      ((state_reg == ST_EMIT) && is_last && m_tready);
    assign load = s_tvalid && s_tready;
    assign cmd.load = load;
    assign cmd.sel = idx_reg;

    always_comb begin
        state_next = state_reg;
        idx_next = idx_reg;
        cnt_next = cnt_reg;
        if (load) begin
            idx_next = '0;
            cnt_next = stat.count;
            state_next = (stat.count == '0) ? ST_ACCEPT : ST_EMIT;
        end else if (state_reg == ST_EMIT && m_tready) begin
            if (is_last) begin
                state_next = ST_ACCEPT;
            end else begin
                idx_next = idx_reg + SEL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACCEPT;
            idx_reg <= '0;
            cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
        end
    end

    `U8D_ASSERT(a_emit_has_words, aclk, aresetn, (state_reg == ST_EMIT) |-> (cnt_reg != '0))
    `U8D_ASSERT(a_idx_in_range, aclk, aresetn, (state_reg == ST_EMIT) |-> ({1'b0, idx_reg} < cnt_reg))
    `U8D_ASSERT(a_empty_load_stays, aclk, aresetn, (load && stat.count == '0) |=> (state_reg == ST_ACCEPT))
    `U8D_ASSERT_RST(a_reset_accept, aclk, !aresetn |=> (state_reg == ST_ACCEPT))

endmodule

@@ hdl/utf8_stream_decoder_with_replay.sv @@
// UTF-8 stream decoder with replay of failed sequences.
// The slave channel takes one word per stream byte; s_tlast marks end of input,
// and then the data byte is ignored. The master channel gives code points;
// m_tuser flags the end result and the range-error result, and m_tlast marks the
// final result caused by one input word. An input word gives zero to four results.
// The first result appears in the cycle after the input word is accepted.
// Results leave one per cycle while the receiver is ready, from a small result
// buffer in the datapath. After a word that gives no result the controller stays
// in accept; otherwise the next input word is taken in the cycle the last
// result leaves. The controller holds one word at a time while it plays out
// the result buffer.
// When the receiver stalls, the current result holds and no input is taken.
// Reset returns the decoder to idle with no pending bytes and sets
// full_unicode_enable to 1. The register is written through cfg_wr_en and
// cfg_wr_data; the user must write it only while idle (the block does not check).
module utf8_stream_decoder_with_replay
    import u8d_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic cfg_wr_en,
    input  logic cfg_wr_data,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic s_tlast,
    output logic m_tvalid,
    input  logic m_tready,
    output logic [23:0] m_tdata,  // [20:0] code_point, [23:21] zero
    output logic [1:0] m_tuser,   // [0] is_end, [1] range_error
    output logic m_tlast
);

    dp_cmd_t cmd;
    dp_stat_t stat;
    res_t res_out;

    u8d_ctrl u_ctrl (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tlast(m_tlast),
        .stat(stat),
        .cmd(cmd)
    );

    u8d_datapath u_datapath (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_byte(s_tdata),
        .end_of_input(s_tlast),
        .cmd(cmd),
        .stat(stat),
        .res_out(res_out)
    );

    assign m_tdata = {3'd0, res_out.code_point};
    assign m_tuser = {res_out.range_error, res_out.is_end};

endmodule

@@ sim/utf8_stream_decoder_with_replay_test.sv @@
`timescale 1ns / 1ps

module utf8_stream_decoder_with_replay_test;
    import u8d_pkg::*;

    localparam int RESET_CYCLES = 12;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [8:0] EOI_WORD = 9'h100;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic is_end;
        logic range_error;
        logic last;
    } cp_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic cfg_wr_data = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0] m_tuser;
    logic m_tlast;

    cp_result_t expected_code_points[$];
    int mismatch_count = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_count;
    logic hold_request = 1'b0;

    logic unicode_enabled;
    logic [1:0] seq_remaining;
    logic [CP_W-1:0] seq_value;
    logic [CP_W-1:0] seq_floor;
    logic [7:0] seq_bytes[HELD_DEPTH];
    logic [1:0] seq_count;

    utf8_stream_decoder_with_replay dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic push_result(input logic [CP_W-1:0] cp, input logic end_flag,
                               input logic rerr, inout int produced);
        cp_result_t r;
        r.code_point = cp;
        r.is_end = end_flag;
        r.range_error = rerr;
        r.last = 1'b0;
        expected_code_points.push_back(r);
        produced++;
    endtask

    task automatic clear_sequence();
        seq_remaining = 2'd0;
        seq_value = '0;
        seq_floor = '0;
        seq_count = 2'd0;
    endtask

    task automatic open_sequence(input logic [7:0] b, input logic [1:0] rem,
                                 input logic [CP_W-1:0] val, input logic [CP_W-1:0] lowest);
        seq_remaining = rem;
        seq_value = val;
        seq_floor = lowest;
        seq_bytes[0] = b;
        seq_count = 2'd1;
    endtask

    task automatic flush_sequence(inout int produced);
        for (int i = 0; i < seq_count; i++) begin
            push_result(ESC_BASE | CP_W'(seq_bytes[i]), 1'b0, 1'b0, produced);
        end
        clear_sequence();
    endtask

    task automatic decode_lead(input logic [7:0] b, inout int produced);
        if (b[7] == 1'b0) begin
            push_result(CP_W'(b), 1'b0, 1'b0, produced);
        end else if (b[7:5] == 3'b110) begin
            open_sequence(b, 2'd1, CP_W'(b[4:0]), MIN_2B);
        end else if (b[7:4] == 4'hE) begin
            open_sequence(b, 2'd2, CP_W'(b[3:0]), MIN_3B);
        end else if (b[7:4] == 4'hF && !unicode_enabled) begin
            push_result('0, 1'b0, 1'b1, produced);
        end else if (b[7:4] == 4'hF && b < LEAD_LIMIT) begin
            open_sequence(b, 2'd3, CP_W'(b[2:0]), MIN_4B);
        end else begin
            push_result(ESC_BASE | CP_W'(b), 1'b0, 1'b0, produced);
        end
    endtask

    task automatic decode_word(input logic [7:0] b, input logic eoi);
        int produced;
        logic [CP_W-1:0] v;
        cp_result_t tail;
        produced = 0;
        if (eoi) begin
            if (seq_remaining != 0) begin
                flush_sequence(produced);
            end
            push_result('0, 1'b1, 1'b0, produced);
        end else if (seq_remaining == 0) begin
            decode_lead(b, produced);
        end else if (b[7:6] == 2'b10) begin
            seq_value = {seq_value[CP_W-7:0], b[5:0]};
            seq_remaining--;
            if (seq_remaining != 0) begin
                if (seq_count < HELD_DEPTH) begin
                    seq_bytes[seq_count] = b;
                    seq_count++;
                end
            end else begin
                v = seq_value;
                if (v < seq_floor || (v <= BMP_MAX && v[15:8] == ESC_HI) || v > CP_MAX) begin
                    flush_sequence(produced);
                    push_result(ESC_BASE | CP_W'(b), 1'b0, 1'b0, produced);
                end else begin
                    clear_sequence();
                    push_result(v, 1'b0, 1'b0, produced);
                end
            end
        end else begin
            flush_sequence(produced);
            decode_lead(b, produced);
        end
        if (produced > 0) begin
            tail = expected_code_points.pop_back();
            tail.last = 1'b1;
            expected_code_points.push_back(tail);
        end
    endtask

    task automatic send_word(input logic [7:0] b, input logic eoi);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= eoi;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        decode_word(b, eoi);
    endtask

    task automatic send_utf8(input logic [CP_W-1:0] cp, input int len, input int keep);
        logic [7:0] enc[4];
        case (len)
            1: enc[0] = {1'b0, cp[6:0]};
            2: begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
            end
            3: begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
            end
            default: begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int i = 0; i < keep; i++) begin
            send_word(enc[i], 1'b0);
        end
    endtask

    function automatic logic [CP_W-1:0] code_point_of_length(input int len);
        case (len)
            1: return CP_W'($urandom_range(32'h7F, 0));
            2: return CP_W'($urandom_range(32'h7FF, 32'h80));
            3: return CP_W'($urandom_range(32'hFFFF, 32'h800));
            default: return CP_W'($urandom_range(32'h10FFFF, 32'h10000));
        endcase
    endfunction

    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        while (expected_code_points.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_unicode_enable(input logic value);
        send_word(8'($urandom_range(255)), 1'b1);
        wait_until_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        unicode_enabled = value;
    endtask

    task automatic run_script(input logic [8:0] words[$]);
        foreach (words[i]) begin
            send_word(words[i][7:0], words[i][8]);
        end
    endtask

    task automatic test_directed_sequences();
        run_script('{9'h000, 9'h07F, 9'h0C2, 9'h080, 9'h0C0, 9'h080,
                     9'h0ED, 9'h0B0, 9'h080, 9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,
                     9'h0F4, 9'h090, 9'h080, 9'h080, 9'h0E2, 9'h082, 9'h041,
                     9'h080, 9'h0FF, 9'h0C3, EOI_WORD, EOI_WORD});
    endtask

    task automatic test_random_stream(input int n_words);
        int sent;
        int kind;
        int len;
        int keep;
        logic [CP_W-1:0] cp;
        sent = 0;
        while (sent < n_words) begin
            kind = $urandom_range(99);
            len = $urandom_range(4, 1);
            if (kind < 55) begin
                send_utf8(code_point_of_length(len), len, len);
                sent += len;
            end else if (kind < 65) begin
                len = $urandom_range(4, 2);
                keep = $urandom_range(len - 1, 1);
                send_utf8(code_point_of_length(len), len, keep);
                sent += keep;
            end else if (kind < 72) begin
                len = $urandom_range(4, 2);
                cp = code_point_of_length(len - 1);
                send_utf8(cp, len, len);
                sent += len;
            end else if (kind < 78) begin
                send_utf8({5'd0, ESC_HI, 8'($urandom_range(255))}, 3, 3);
                sent += 3;
            end else if (kind < 82) begin
                send_utf8(CP_W'($urandom_range(32'h1FFFFF, 32'h110000)), 4, 4);
                sent += 4;
            end else if (kind < 94) begin
                send_word(8'($urandom_range(255)), 1'b0);
                sent++;
            end else begin
                send_word(8'($urandom_range(255)), 1'b1);
                sent++;
            end
        end
    endtask

    task automatic test_unicode_disabled();
        write_unicode_enable(1'b0);
        run_script('{9'h0F0, 9'h0F4, 9'h0F7, 9'h0FF, 9'h0E2, 9'h082, 9'h0F0,
                     9'h0C2, 9'h080, 9'h0F0, 9'h090, EOI_WORD});
        test_random_stream(15);
        write_unicode_enable(1'b1);
    endtask

    task automatic test_receiver_hold();
        hold_request = 1'b1;
        test_random_stream(15);
    endtask

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) begin
                    @(posedge aclk);
                end
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        cp_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_code_points.size() == 0) begin
                $error("result word with no expectation: code_point %h is_end %b range_error %b",
                       m_tdata[CP_W-1:0], m_tuser[0], m_tuser[1]);
                mismatch_count++;
            end else begin
                want = expected_code_points.pop_front();
                if (m_tdata[CP_W-1:0] !== want.code_point) begin
                    $error("code_point expected %h, got %h", want.code_point, m_tdata[CP_W-1:0]);
                    mismatch_count++;
                end
                if (m_tuser[0] !== want.is_end) begin
                    $error("is_end expected %b, got %b", want.is_end, m_tuser[0]);
                    mismatch_count++;
                end
                if (m_tuser[1] !== want.range_error) begin
                    $error("range_error expected %b, got %b", want.range_error, m_tuser[1]);
                    mismatch_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last expected %b, got %b", want.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("utf8_stream_decoder_with_replay test failed");
            $finish;
        end
    end

    initial begin
        unicode_enabled = 1'b1;
        clear_sequence();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_sequences();
        test_random_stream(20);

        send_idle_pct = 57;
        test_random_stream(20);

        send_idle_pct = 0;
        stall_pct = 57;
        test_unicode_disabled();

        send_idle_pct = 38;
        stall_pct = 38;
        test_random_stream(20);
        test_receiver_hold();

        wait_until_drained();
        if (mismatch_count == 0 && expected_code_points.size() == 0) begin
            $display("utf8_stream_decoder_with_replay test passed");
        end else begin
            $display("utf8_stream_decoder_with_replay test failed");
        end
        $finish;
    end

endmodule
